>>> src/hpid_pkg.sv
package hpid_pkg;

  localparam int TEMP_WIDTH = 14;
  localparam int TGT_W = 13;
  localparam int GAIN_W = 16;
  localparam int MS_W = 16;
  localparam int SAFE_W = 17;
  localparam int INTEG_W = 22;
  localparam int PWR_W = 8;
  localparam int CMD_W = 2;
  localparam int FAULT_W = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W = (TEMP_WIDTH > 16) ? TEMP_WIDTH : 16;
  localparam int CMP_W = ((TEMP_WIDTH > TGT_W) ? TEMP_WIDTH : TGT_W) + 2;
  localparam int E_W = CMP_W;
  localparam int MA_W = GAIN_W + E_W + 2;
  localparam int MB_W = ((E_W + 2) > 28) ? (E_W + 2) : 28;
  localparam int P_W = MA_W + MB_W;
  localparam int K_W = MS_W + 10;
  localparam int DEN_W = MS_W + 7 + 15;
  localparam int INTEG_MAX = 4080000;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TARGET = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ENABLE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_DISABLE = 2'd3;

  localparam logic [FAULT_W-1:0] FAULT_NONE = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_OVER = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_LOW = 2'd2;
  localparam logic [FAULT_W-1:0] FAULT_RUNAWAY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_TEMP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 3'd6;

  localparam logic [2:0] STEP_E_DT = 3'd0;
  localparam logic [2:0] STEP_GP_E = 3'd1;
  localparam logic [2:0] STEP_P_K = 3'd2;
  localparam logic [2:0] STEP_GI_DT = 3'd3;
  localparam logic [2:0] STEP_I_INT = 3'd4;
  localparam logic [2:0] STEP_GD_DE = 3'd5;
  localparam logic [2:0] STEP_D_MEG = 3'd6;
  localparam logic [2:0] STEP_SUM = 3'd7;

  typedef struct packed {
    logic       load;
    logic       exec;
    logic       pid_en;
    logic [2:0] pid_step;
    logic       div_start;
    logic       div_en;
    logic [2:0] div_bit;
    logic       fin;
    logic       pub;
  } ctl_t;

  typedef struct packed {
    logic pid_go;
  } sts_t;

endpackage

>>> src/hpid_in_if.sv
interface hpid_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [hpid_pkg::CMD_W-1:0]            cmd;
  logic signed [hpid_pkg::TEMP_WIDTH-1:0] sample_temp;
  logic [hpid_pkg::MS_W-1:0]             elapsed_ms;
  logic signed [hpid_pkg::TEMP_WIDTH-1:0] new_target;

  modport source (output valid, cmd, sample_temp, elapsed_ms, new_target, input ready);
  modport sink (input valid, cmd, sample_temp, elapsed_ms, new_target, output ready);
endinterface

>>> src/hpid_out_if.sv
interface hpid_out_if;
  logic                          valid;
  logic                          ready;
  logic [hpid_pkg::PWR_W-1:0]    heater_power;
  logic                          heater_on;
  logic                          runaway_seen;
  logic [hpid_pkg::FAULT_W-1:0]  fault;
  logic [hpid_pkg::TGT_W-1:0]    target_now;

  modport source (output valid, heater_power, heater_on, runaway_seen, fault, target_now,
                  input ready);
  modport sink (input valid, heater_power, heater_on, runaway_seen, fault, target_now,
                output ready);
endinterface

>>> src/hpid_datapath.sv
module hpid_datapath (
  input  logic                                   clk,
  input  logic                                   rst,
  input  hpid_pkg::ctl_t                         ctl,
  output hpid_pkg::sts_t                         sts,
  input  logic                                   cfg_we,
  input  logic [hpid_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hpid_pkg::CFG_W-1:0]             cfg_data,
  input  logic [hpid_pkg::CMD_W-1:0]             cmd,
  input  logic signed [hpid_pkg::TEMP_WIDTH-1:0] sample_temp,
  input  logic [hpid_pkg::MS_W-1:0]              elapsed_ms,
  input  logic signed [hpid_pkg::TEMP_WIDTH-1:0] new_target,
  output logic [hpid_pkg::PWR_W-1:0]             heater_power,
  output logic                                   heater_on,
  output logic                                   runaway_seen,
  output logic [hpid_pkg::FAULT_W-1:0]           fault,
  output logic [hpid_pkg::TGT_W-1:0]             target_now
);

  localparam int TW = hpid_pkg::TEMP_WIDTH;
  localparam int CW = hpid_pkg::CMP_W;
  localparam int EW = hpid_pkg::E_W;
  localparam int AW = hpid_pkg::MA_W;
  localparam int BW = hpid_pkg::MB_W;
  localparam int PW = hpid_pkg::P_W;
  localparam int MW = hpid_pkg::MS_W;
  localparam int SW = hpid_pkg::SAFE_W;
  localparam int GW = hpid_pkg::GAIN_W;
  localparam int TG = hpid_pkg::TGT_W;
  localparam int IW = hpid_pkg::INTEG_W;

  logic [GW-1:0]        gain_p, gain_i, gain_d;
  logic [TG-1:0]        temp_limit;
  logic signed [TW-1:0] min_temp;
  logic [MW-1:0]        period;
  logic [TG-1:0]        margin;

  logic [hpid_pkg::CMD_W-1:0] cmd_r;
  logic signed [TW-1:0]       sample_r, newt_r;
  logic [MW-1:0]              elapsed_r;

  logic                 enabled, runaway;
  logic [TG-1:0]        target;
  logic [IW-1:0]        integ;
  logic signed [EW-1:0] prev_err;
  logic [MW-1:0]        pid_el;
  logic [SW-1:0]        safe_el;
  logic signed [TW-1:0] ref_t;
  logic [hpid_pkg::PWR_W-1:0]   power;
  logic [hpid_pkg::FAULT_W-1:0] fault_r;

  logic signed [PW-1:0] prod, acc, rem;
  logic [hpid_pkg::K_W-1:0]   k;
  logic [hpid_pkg::DEN_W-1:0] den;
  logic [hpid_pkg::PWR_W-1:0] q;
  logic                       skip;

  logic signed [CW-1:0] cur_x, tgt_x, max_x, min_x, mrg_x, ref_x, nt_x, e;
  logic [MW:0]          pid_sum;
  logic [MW-1:0]        pid_new, dt;
  logic [SW:0]          safe_sum;
  logic [SW-1:0]        safe_new;
  logic                 over, low, active, chk, short_fall, stall, trip;
  logic signed [EW:0]   diff;
  logic signed [AW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic signed [PW-1:0] isum, dsh, dtop;

  assign cur_x = CW'(sample_r);
  assign tgt_x = $signed(CW'(target));
  assign max_x = $signed(CW'(temp_limit));
  assign min_x = CW'(min_temp);
  assign mrg_x = $signed(CW'(margin));
  assign ref_x = CW'(ref_t);
  assign nt_x = CW'(newt_r);
  assign e = tgt_x - cur_x;

  assign pid_sum = {1'b0, pid_el} + (MW + 1)'(elapsed_r);
  assign pid_new = pid_sum[MW] ? '1 : pid_sum[MW-1:0];
  assign safe_sum = {1'b0, safe_el} + (SW + 1)'(elapsed_r);
  assign safe_new = safe_sum[SW] ? '1 : safe_sum[SW-1:0];

  assign over = cur_x > max_x;
  assign low = (cur_x < min_x) && (target != '0);
  assign active = enabled && (target != '0);
  assign chk = active && (safe_new > SW'(period));
  assign short_fall = (tgt_x - cur_x) > mrg_x;
  assign stall = (cur_x - ref_x) < $signed(CW'(16));
  assign trip = chk && short_fall && stall;
  assign sts.pid_go = (cmd_r == hpid_pkg::CMD_TICK) && !over && !low && active && !trip;

  assign dt = (pid_el == '0) ? MW'(1) : pid_el;
  assign diff = (EW + 1)'(e) - (EW + 1)'(prev_err);
  assign isum = $signed(PW'(integ)) + prod;
  assign dtop = $signed(PW'({den, 8'b0}));
  assign dsh = $signed(PW'(den) << ctl.div_bit);

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctl.pid_step)
      hpid_pkg::STEP_E_DT: begin
        op_a = AW'(e);
        op_b = $signed(BW'(dt));
      end
      hpid_pkg::STEP_GP_E: begin
        op_a = $signed(AW'(gain_p));
        op_b = BW'(e);
      end
      hpid_pkg::STEP_P_K: begin
        op_a = $signed(prod[AW-1:0]);
        op_b = $signed(BW'(k));
      end
      hpid_pkg::STEP_GI_DT: begin
        op_a = $signed(AW'(gain_i));
        op_b = $signed(BW'(dt));
      end
      hpid_pkg::STEP_I_INT: begin
        op_a = $signed(prod[AW-1:0]);
        op_b = $signed(BW'(integ));
      end
      hpid_pkg::STEP_GD_DE: begin
        op_a = $signed(AW'(gain_d));
        op_b = BW'(diff);
      end
      hpid_pkg::STEP_D_MEG: begin
        op_a = $signed(prod[AW-1:0]);
        op_b = $signed(BW'(1000000));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p <= '0;
      gain_i <= '0;
      gain_d <= '0;
      temp_limit <= TG'(4000);
      min_temp <= TW'(80);
      period <= MW'(20000);
      margin <= TG'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpid_pkg::REG_GAIN_P:   gain_p <= cfg_data[GW-1:0];
        hpid_pkg::REG_GAIN_I:   gain_i <= cfg_data[GW-1:0];
        hpid_pkg::REG_GAIN_D:   gain_d <= cfg_data[GW-1:0];
        hpid_pkg::REG_MAX_TEMP: temp_limit <= cfg_data[TG-1:0];
        hpid_pkg::REG_MIN_TEMP: min_temp <= $signed(cfg_data[TW-1:0]);
        hpid_pkg::REG_PERIOD:   period <= cfg_data[MW-1:0];
        hpid_pkg::REG_MARGIN:   margin <= cfg_data[TG-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= cmd;
      sample_r <= sample_temp;
      elapsed_r <= elapsed_ms;
      newt_r <= new_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b0;
      runaway <= 1'b0;
      target <= '0;
      integ <= '0;
      prev_err <= '0;
      pid_el <= '0;
      safe_el <= '0;
      ref_t <= '0;
      power <= '0;
      fault_r <= hpid_pkg::FAULT_NONE;
    end else if (ctl.exec) begin
      fault_r <= hpid_pkg::FAULT_NONE;
      unique case (cmd_r)
        hpid_pkg::CMD_TICK: begin
          pid_el <= pid_new;
          safe_el <= safe_new;
          if (over || low || trip) begin
            enabled <= 1'b0;
            target <= '0;
            power <= '0;
            if (over) fault_r <= hpid_pkg::FAULT_OVER;
            else if (low) fault_r <= hpid_pkg::FAULT_LOW;
            else begin
              fault_r <= hpid_pkg::FAULT_RUNAWAY;
              runaway <= 1'b1;
            end
          end else if (!active || chk) begin
            ref_t <= sample_r;
            safe_el <= '0;
            if (!active) power <= '0;
          end
        end
        hpid_pkg::CMD_TARGET: begin
          if (nt_x < 0) target <= '0;
          else if (nt_x > max_x) target <= temp_limit;
          else target <= nt_x[TG-1:0];
          integ <= '0;
          prev_err <= '0;
        end
        hpid_pkg::CMD_ENABLE: begin
          enabled <= 1'b1;
          runaway <= 1'b0;
        end
        hpid_pkg::CMD_DISABLE: begin
          enabled <= 1'b0;
          power <= '0;
        end
        default: ;
      endcase
    end else if (ctl.pid_en) begin
      if (ctl.pid_step == hpid_pkg::STEP_GP_E) begin
        if (isum > $signed(PW'(hpid_pkg::INTEG_MAX))) integ <= IW'(hpid_pkg::INTEG_MAX);
        else if (isum < 0) integ <= '0;
        else integ <= isum[IW-1:0];
      end
      if (ctl.pid_step == hpid_pkg::STEP_SUM) begin
        prev_err <= e;
        pid_el <= '0;
      end
    end else if (ctl.fin) begin
      power <= q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pid_en) begin
      prod <= op_a * op_b;
      case (ctl.pid_step)
        hpid_pkg::STEP_GP_E:  k <= (hpid_pkg::K_W'(dt) << 10) - (hpid_pkg::K_W'(dt) << 4)
                                   - (hpid_pkg::K_W'(dt) << 3);
        hpid_pkg::STEP_GI_DT: acc <= prod;
        hpid_pkg::STEP_GD_DE: acc <= acc + prod;
        hpid_pkg::STEP_SUM: begin
          acc <= acc + prod;
          den <= ((hpid_pkg::DEN_W'(dt) << 7) - (hpid_pkg::DEN_W'(dt) << 1)
                  - hpid_pkg::DEN_W'(dt)) << 15;
        end
        default: ;
      endcase
    end
    if (ctl.div_start) begin
      rem <= acc;
      skip <= (acc <= 0) || (acc >= dtop);
      q <= ((acc > 0) && (acc >= dtop)) ? '1 : '0;
    end else if (ctl.div_en) begin
      if (!skip && (rem >= dsh)) begin
        rem <= rem - dsh;
        q[ctl.div_bit] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pub) begin
      heater_power <= power;
      heater_on <= enabled;
      runaway_seen <= runaway;
      fault <= fault_r;
      target_now <= target;
    end
  end

endmodule

>>> src/hpid_ctrl.sv
module hpid_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  hpid_pkg::sts_t sts,
  output hpid_pkg::ctl_t ctl
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_PID = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV = 3'd4;
  localparam logic [2:0] S_FIN = 3'd5;
  localparam logic [2:0] S_PUB = 3'd6;

  logic [2:0] state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ctl = '0;
    ctl.pid_step = cnt;
    ctl.div_bit = cnt;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        ctl.exec = 1'b1;
        cnt_next = '0;
        state_next = sts.pid_go ? S_PID : S_PUB;
      end
      S_PID: begin
        ctl.pid_en = 1'b1;
        cnt_next = cnt + 3'd1;
        if (cnt == hpid_pkg::STEP_SUM) state_next = S_DSTART;
      end
      S_DSTART: begin
        ctl.div_start = 1'b1;
        cnt_next = 3'd7;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_en = 1'b1;
        cnt_next = cnt - 3'd1;
        if (cnt == 3'd0) state_next = S_FIN;
      end
      S_FIN: begin
        ctl.fin = 1'b1;
        state_next = S_PUB;
      end
      S_PUB: begin
        if (out_free) begin
          ctl.pub = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (ctl.pub) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_EXEC))
    else $error("accepted transaction did not start execution");

  a_no_pid_skip: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !sts.pid_go) |=> (state == S_PUB))
    else $error("non-PID transaction entered the PID sequence");

  a_fin_after_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> $past(state == S_DIV && cnt == 3'd0))
    else $error("power update without completed division");

endmodule

>>> src/heater_pid_with_runaway_guard_top.sv
// Channel   Dir  Handshake         Payload
// in_ch     in   valid/ready       cmd, sample_temp, elapsed_ms, new_target
// out_ch    out  valid/ready       heater_power, heater_on, runaway_seen, fault, target_now
// cfg       in   cfg_we            cfg_index, cfg_data
//
// One transaction at a time. Set target, enable, disable and a tick that does
// not run the PID go from accept through the execute and publish states. A tick
// that runs the PID also takes 8 steps on the shared multiplier and 8 steps of
// restoring division for the duty value.
// rst is synchronous and active high; no clearing pass follows it.
// A stalled result holds in the output register; the next transaction is
// still accepted and holds its result until the stalled one is taken.
module heater_pid_with_runaway_guard_top (
  input  logic                           clk,
  input  logic                           rst,
  hpid_in_if.sink                        in_ch,
  hpid_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [hpid_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hpid_pkg::CFG_W-1:0]     cfg_data
);

  hpid_pkg::ctl_t ctl;
  hpid_pkg::sts_t sts;

  hpid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .ctl       (ctl)
  );

  hpid_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (in_ch.cmd),
    .sample_temp  (in_ch.sample_temp),
    .elapsed_ms   (in_ch.elapsed_ms),
    .new_target   (in_ch.new_target),
    .heater_power (out_ch.heater_power),
    .heater_on    (out_ch.heater_on),
    .runaway_seen (out_ch.runaway_seen),
    .fault        (out_ch.fault),
    .target_now   (out_ch.target_now)
  );

endmodule
